// ----- sv/psrf_pkg.sv -----
// Shared types and constants for the path slice run filter.
package psrf_pkg;

	// Width of one slice bitmap and of the run length threshold.
	localparam int SLICE_W = 64;
	localparam int MIN_RUN_W = 7;
	localparam int COUNT_W = 6;

	// Slices the scanner examines in one cycle.
	localparam int SCAN_LANES = 4;

	// Status of the queue between the accumulator and the scanner.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

// ----- sv/psrf_front.sv -----
// Front end: accepts edge bitmaps and builds the path intersection.
module psrf_front
	import psrf_pkg::*;
#(
	parameter int NUM_SLICES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [SLICE_W-1:0] edge_slices,
	input  logic               last_edge,
	output logic               push,
	output logic [SLICE_W-1:0] push_bits
);

	localparam logic [SLICE_W-1:0] SLICE_MASK = {SLICE_W{1'b1}} >> (SLICE_W - NUM_SLICES);

	logic [SLICE_W-1:0] acc_q;
	logic               first_q;
	logic [SLICE_W-1:0] acc_next;

	// The first edge of a path loads the accumulator, later edges narrow it.
	always_comb begin
		if (first_q) begin
			acc_next = edge_slices & SLICE_MASK;
		end else begin
			acc_next = acc_q & edge_slices & SLICE_MASK;
		end
	end

	assign push      = accept & last_edge;
	assign push_bits = acc_next;

	// The last edge hands the intersection to the queue and starts a new path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= '0;
			first_q <= 1'b1;
		end else if (accept) begin
			if (last_edge) begin
				acc_q   <= '0;
				first_q <= 1'b1;
			end else begin
				acc_q   <= acc_next;
				first_q <= 1'b0;
			end
		end
	end

endmodule

// ----- sv/psrf_queue.sv -----
// Two-entry queue of finished path intersections waiting for the scanner.
module psrf_queue
	import psrf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic [SLICE_W-1:0] push_bits,
	input  logic               pop,
	output logic [SLICE_W-1:0] pop_bits,
	output q_status_t          status
);

	logic [SLICE_W-1:0] mem_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;

	assign pop_bits     = mem_q[rd_ptr_q];
	assign status.full  = (count_q == 2'd2);
	assign status.empty = (count_q == 2'd0);

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_bits;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

endmodule

// ----- sv/psrf_back.sv -----
// Back end: scans an intersection for runs a few slices per cycle.
module psrf_back
	import psrf_pkg::*;
#(
	parameter int NUM_SLICES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [MIN_RUN_W-1:0] min_run,
	input  q_status_t            q_status,
	input  logic [SLICE_W-1:0]   q_bits,
	output logic                 pop,
	output logic                 done,
	output logic [SLICE_W-1:0]   path_slices,
	output logic [SLICE_W-1:0]   usable_slices,
	output logic [COUNT_W-1:0]   fragment_count
);

	localparam int STEPS  = (NUM_SLICES + SCAN_LANES - 1) / SCAN_LANES;
	localparam int STEP_W = $clog2(STEPS + 1);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(STEPS - 1);

	typedef enum logic {
		ST_IDLE,
		ST_SCAN
	} state_t;

	state_t             state_q;
	logic [STEP_W-1:0]  step_q;
	logic [SLICE_W-1:0] bits_q;
	logic [SLICE_W-1:0] work_q;
	logic [SLICE_W-1:0] pos_q;
	logic [SLICE_W-1:0] cur_q;
	logic [SLICE_W-1:0] use_q;
	logic [6:0]         len_q;
	logic [6:0]         cnt_q;

	logic [SLICE_W-1:0] cur_d;
	logic [SLICE_W-1:0] use_d;
	logic [SLICE_W-1:0] use_fin;
	logic [6:0]         len_d;
	logic [6:0]         cnt_d;

	assign pop = (state_q == ST_IDLE) && !q_status.empty;

	// One slice per lane: extend, open or close the current run.
	always_comb begin
		cur_d = cur_q;
		use_d = use_q;
		len_d = len_q;
		cnt_d = cnt_q;
		for (int k = 0; k < SCAN_LANES; k++) begin
			if (work_q[k]) begin
				if (len_d == 7'd0) begin
					cnt_d = cnt_d + 7'd1;
				end
				cur_d = cur_d | (pos_q << k);
				len_d = len_d + 7'd1;
			end else begin
				if ((len_d != 7'd0) && (len_d >= min_run)) begin
					use_d = use_d | cur_d;
				end
				cur_d = '0;
				len_d = 7'd0;
			end
		end
		// A run that reaches the top slice closes at the end of the scan.
		use_fin = use_d;
		if ((len_d != 7'd0) && (len_d >= min_run)) begin
			use_fin = use_d | cur_d;
		end
	end

	// Sequencer, scan registers and the result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			done    <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (!q_status.empty) begin
						state_q <= ST_SCAN;
						step_q  <= '0;
						bits_q  <= q_bits;
						work_q  <= q_bits;
						pos_q   <= SLICE_W'(1);
						cur_q   <= '0;
						use_q   <= '0;
						len_q   <= 7'd0;
						cnt_q   <= 7'd0;
					end
				end
				ST_SCAN: begin
					work_q <= work_q >> SCAN_LANES;
					pos_q  <= pos_q << SCAN_LANES;
					cur_q  <= cur_d;
					use_q  <= use_d;
					len_q  <= len_d;
					cnt_q  <= cnt_d;
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q        <= ST_IDLE;
						done           <= 1'b1;
						path_slices    <= bits_q;
						usable_slices  <= use_fin;
						fragment_count <= cnt_d[COUNT_W-1:0];
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ----- sv/path_slice_run_filter.sv -----
// Top level of the path slice run filter: edge accumulator, queue and run scanner.
//
// Usage: drive one edge bitmap per transaction on edge_slices with last_edge,
// and raise start. The edge is taken at a rising edge where start is high and
// busy is low. The first edge of a path loads the intersection and every later
// edge is ANDed into it in the same cycle, so edges can follow back to back.
// The edge marked last closes the path and moves the intersection into a
// two-entry queue; busy is high only while that queue is full.
// The scanner pops a path and walks its bitmap four slices a cycle. A result
// appears for one cycle with done high: path_slices, usable_slices (runs of
// at least min_run slices) and fragment_count. A closed path waits in the
// queue, then the scanner pops it and registers done at its last scan step;
// the scanner takes a new path only once it has finished the last one and
// is back in idle. The receiver cannot stall: the result must be captured in
// the cycle done is high.
// min_run is written through cfg_valid/cfg_data; cfg_ready is always high.
// Write it only while no path is in flight. Reset sets min_run to one, empties
// the queue and makes the next edge start a new path.
module path_slice_run_filter
	import psrf_pkg::*;
#(
	parameter int NUM_SLICES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic [SLICE_W-1:0]   edge_slices,
	input  logic                 last_edge,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [MIN_RUN_W-1:0] cfg_data,
	output logic                 done,
	output logic [SLICE_W-1:0]   path_slices,
	output logic [SLICE_W-1:0]   usable_slices,
	output logic [COUNT_W-1:0]   fragment_count
);

	logic                 accept;
	logic                 push;
	logic [SLICE_W-1:0]   push_bits;
	logic                 pop;
	logic [SLICE_W-1:0]   pop_bits;
	q_status_t            q_status;
	logic [MIN_RUN_W-1:0] min_run_q;

	assign busy      = q_status.full;
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Run length threshold register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_run_q <= MIN_RUN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			min_run_q <= cfg_data;
		end
	end

	psrf_front #(
		.NUM_SLICES(NUM_SLICES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.edge_slices(edge_slices),
		.last_edge  (last_edge),
		.push       (push),
		.push_bits  (push_bits)
	);

	psrf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_bits(push_bits),
		.pop      (pop),
		.pop_bits (pop_bits),
		.status   (q_status)
	);

	psrf_back #(
		.NUM_SLICES(NUM_SLICES)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.min_run       (min_run_q),
		.q_status      (q_status),
		.q_bits        (pop_bits),
		.pop           (pop),
		.done          (done),
		.path_slices   (path_slices),
		.usable_slices (usable_slices),
		.fragment_count(fragment_count)
	);

	// Kept runs are always part of the intersection.
	a_usable_subset: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((usable_slices & ~path_slices) == '0))
		else $error("usable_slices holds a slice outside path_slices");

	// An empty intersection has no runs and a nonempty one has at least one.
	a_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ((path_slices == '0) == (fragment_count == '0)))
		else $error("fragment_count disagrees with path_slices");

	// A result strobe lasts one cycle, since the scanner passes through idle between scans.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held for more than one cycle");

	// A full queue never takes another path.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_status.full |-> !push)
		else $error("push into a full queue");

endmodule

// ----- verif/path_slice_run_filter_checker.sv -----
// Checker for the path slice run filter: predicts each path result and compares it.
`timescale 1ns / 100ps
module psrf_checker
	import psrf_pkg::*;
#(
	parameter int NUM_SLICES = 64
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic [SLICE_W-1:0]   edge_slices,
	input  logic                 last_edge,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [MIN_RUN_W-1:0] cfg_data,
	input  logic                 done,
	input  logic [SLICE_W-1:0]   path_slices,
	input  logic [SLICE_W-1:0]   usable_slices,
	input  logic [COUNT_W-1:0]   fragment_count,
	output int                   mismatches,
	output int                   open_paths,
	output int                   paths_checked
);

	typedef struct packed {
		logic [SLICE_W-1:0] path;
		logic [SLICE_W-1:0] usable;
		logic [COUNT_W-1:0] frags;
	} path_result_t;

	// Slices at or above NUM_SLICES never count as free.
	localparam logic [SLICE_W-1:0] SLICE_MASK = {SLICE_W{1'b1}} >> (SLICE_W - NUM_SLICES);

	logic [SLICE_W-1:0]   common_free;
	logic                 path_opens;
	logic [MIN_RUN_W-1:0] run_floor;
	path_result_t         pending_results[$];

	// Walk the intersection from slice 0 upward, counting runs and keeping the long ones.
	function automatic path_result_t close_path(input logic [SLICE_W-1:0] bits,
			input logic [MIN_RUN_W-1:0] floor_len);
		path_result_t res;
		logic [SLICE_W-1:0] run_bits;
		int run_len;
		int i;
		res.path = bits;
		res.usable = '0;
		res.frags = '0;
		run_bits = '0;
		run_len = 0;
		for (i = 0; i <= NUM_SLICES; i++) begin
			if (i < NUM_SLICES && bits[i]) begin
				if (run_len == 0)
					res.frags++;
				run_bits[i] = 1'b1;
				run_len++;
			end else begin
				if (run_len != 0 && run_len >= floor_len)
					res.usable |= run_bits;
				run_bits = '0;
				run_len = 0;
			end
		end
		return res;
	endfunction

	// Print one line per mismatch and count it.
	task automatic report_mismatch(input string msg);
		$display("%0t ns: %s", $time, msg);
		mismatches++;
	endtask

	// Track min_run writes and edge transactions, then check each result as it appears.
	always @(posedge clk or negedge arst_n) begin
		path_result_t want;
		if (!arst_n) begin
			common_free = '0;
			path_opens = 1'b1;
			run_floor = MIN_RUN_W'(1);
			pending_results.delete();
			open_paths <= 0;
		end else begin
			if (cfg_valid && cfg_ready)
				run_floor = cfg_data;
			if (start && !busy) begin
				if (path_opens)
					common_free = edge_slices & SLICE_MASK;
				else
					common_free &= edge_slices & SLICE_MASK;
				path_opens = 1'b0;
				if (last_edge) begin
					pending_results.push_back(close_path(common_free, run_floor));
					common_free = '0;
					path_opens = 1'b1;
				end
			end
			if (done) begin
				if (pending_results.size() == 0) begin
					report_mismatch($sformatf("result %h with no path closed", path_slices));
				end else begin
					want = pending_results.pop_front();
					paths_checked++;
					if (path_slices !== want.path)
						report_mismatch($sformatf("path_slices %h, expected %h",
							path_slices, want.path));
					if (usable_slices !== want.usable)
						report_mismatch($sformatf("usable_slices %h, expected %h",
							usable_slices, want.usable));
					if (fragment_count !== want.frags)
						report_mismatch($sformatf("fragment_count %0d, expected %0d",
							fragment_count, want.frags));
				end
			end
			open_paths <= pending_results.size();
		end
	end

endmodule

// ----- verif/testbench.sv -----
// Top of the path slice run filter testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps
module testbench;
	import psrf_pkg::*;

	localparam int NUM_SLICES = 64;
	localparam int DRAIN_CYCLES = 24;
	localparam int STALL_LIMIT = 2000;
	localparam int PHASES = 10;
	localparam int PHASE_EDGES = 76;
	localparam logic [SLICE_W-1:0] ALL_FREE = '1;
	localparam logic [SLICE_W-1:0] TOP_CLEAR = {1'b0, {(SLICE_W-1){1'b1}}};

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	logic [SLICE_W-1:0]   edge_slices;
	logic                 last_edge;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [MIN_RUN_W-1:0] cfg_data;
	logic                 done;
	logic [SLICE_W-1:0]   path_slices;
	logic [SLICE_W-1:0]   usable_slices;
	logic [COUNT_W-1:0]   fragment_count;

	int mismatches;
	int open_paths;
	int paths_checked;
	int edges_sent;
	int paths_sent;
	int idle_pct;
	int quiet_cycles;

	path_slice_run_filter #(.NUM_SLICES(NUM_SLICES)) dut (.*);

	psrf_checker #(.NUM_SLICES(NUM_SLICES)) result_check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: end the run if nothing moves on any channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || (cfg_valid && cfg_ready) || done) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == STALL_LIMIT) begin
			$display("Watchdog: no transaction for %0d cycles.", STALL_LIMIT);
			$display("FAILURE");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Bitmap of alternating free and busy runs with random lengths.
	function automatic logic [SLICE_W-1:0] run_pattern(input int unsigned longest);
		logic [SLICE_W-1:0] bits;
		logic fill;
		int pos;
		int len;
		int k;
		bits = '0;
		pos = 0;
		fill = 1'($urandom_range(1));
		while (pos < SLICE_W) begin
			len = $urandom_range(1, longest);
			for (k = 0; k < len && pos < SLICE_W; k++) begin
				bits[pos] = fill;
				pos++;
			end
			fill = !fill;
		end
		return bits;
	endfunction

	// One edge of a path: mostly the path's base pattern plus sparse extra free slices.
	function automatic logic [SLICE_W-1:0] random_edge(input logic [SLICE_W-1:0] base);
		case ($urandom_range(15))
			0: return ALL_FREE;
			1: return '0;
			2, 3: return {$urandom, $urandom};
			default: return base | ({$urandom, $urandom} & {$urandom, $urandom} &
				{$urandom, $urandom});
		endcase
	endfunction

	// Offer one edge transaction, idling first at the phase's rate; start stays high on return.
	task automatic send_edge(input logic [SLICE_W-1:0] bits, input logic closes);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			edge_slices <= {$urandom, $urandom};
			last_edge <= 1'($urandom_range(1));
			@(posedge clk);
		end
		start <= 1'b1;
		edge_slices <= bits;
		last_edge <= closes;
		do @(posedge clk); while (busy);
		edges_sent++;
		if (closes)
			paths_sent++;
	endtask

	// Wait until every closed path has produced its result.
	task automatic wait_drained();
		do @(posedge clk); while (open_paths != 0);
	endtask

	task automatic write_min_run(input logic [MIN_RUN_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		cfg_data <= MIN_RUN_W'($urandom);
	endtask

	// A path of one to ten hops built around a shared run pattern.
	task automatic send_random_path();
		logic [SLICE_W-1:0] base;
		int hops;
		int pick;
		int k;
		if ($urandom_range(3) == 0)
			base = run_pattern($urandom_range(1, SLICE_W));
		else
			base = run_pattern($urandom_range(1, 12));
		pick = $urandom_range(9);
		if (pick < 4)
			hops = 1;
		else if (pick < 7)
			hops = 2;
		else if (pick < 9)
			hops = 3;
		else
			hops = $urandom_range(4, 10);
		for (k = 0; k < hops; k++)
			send_edge(random_edge(base), k == hops - 1);
		// Now and then hold off until the block has emptied.
		if ($urandom_range(15) == 0) begin
			start <= 1'b0;
			wait_drained();
		end
	endtask

	initial begin
		logic [MIN_RUN_W-1:0] floor_len;
		int phase_end;
		int p;
		arst_n <= 1'b0;
		start <= 1'b0;
		edge_slices <= '0;
		last_edge <= 1'b0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		idle_pct = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed paths at the reset min_run of one.
		send_edge(ALL_FREE, 1'b1);
		send_edge('0, 1'b1);
		send_edge({32{2'b01}}, 1'b1);
		send_edge({32{2'b10}}, 1'b1);
		send_edge(64'h8000_0000_0000_0001, 1'b1);
		send_edge(ALL_FREE, 1'b0);
		send_edge({8{8'h0F}}, 1'b0);
		send_edge({4{16'hFF00}}, 1'b1);
		send_edge(TOP_CLEAR, 1'b1);
		send_edge(64'hFFFF_FFFF_FFFF_FFFE, 1'b0);
		send_edge(64'h0FFF_FFFF_FFFF_FFFF, 1'b1);
		send_edge(64'h0000_0000_0000_0007, 1'b0);
		send_edge(ALL_FREE, 1'b0);
		send_edge(64'h0000_0000_0000_00FF, 1'b1);

		// Random phases, each with its own min_run and idle rate.
		for (p = 0; p < PHASES; p++) begin
			start <= 1'b0;
			wait_drained();
			repeat (DRAIN_CYCLES) @(posedge clk);
			case (p)
				0: floor_len = MIN_RUN_W'(0);
				1: floor_len = MIN_RUN_W'(64);
				2: floor_len = MIN_RUN_W'(63);
				3: floor_len = MIN_RUN_W'(127);
				4: floor_len = MIN_RUN_W'(65);
				5: floor_len = MIN_RUN_W'(2);
				6: floor_len = MIN_RUN_W'(1);
				default: floor_len = MIN_RUN_W'($urandom_range(3, 24));
			endcase
			write_min_run(floor_len);
			idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 81 : 18;
			// A full path and a one-short path probe the top min_run values.
			send_edge(ALL_FREE, 1'b1);
			send_edge(TOP_CLEAR, 1'b1);
			phase_end = edges_sent + PHASE_EDGES;
			while (edges_sent < phase_end)
				send_random_path();
		end

		start <= 1'b0;
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Drove %0d edges in %0d paths over %0d min_run values including reset.",
			edges_sent, paths_sent, PHASES + 1);
		$display("Compared %0d path results with senders idle at 0, 18 and 81 percent.",
			paths_checked);
		if (mismatches == 0 && open_paths == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
